### rtl/ubrf_pkg.sv
// Shared types and constants for the buffered UART ring FIFO block.
`default_nettype none
package ubrf_pkg;

    // Ring depths; one slot of each ring stays empty.
    localparam int RX_DEPTH = 128;
    localparam int TX_DEPTH = 1024;
    localparam int RX_PTR_W = $clog2(RX_DEPTH);
    localparam int TX_PTR_W = $clog2(TX_DEPTH);

    // Operation codes carried by each input word.
    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_GET   = 2'd1,
        OP_IRQ   = 2'd2,
        OP_FLUSH = 2'd3
    } t_opcode;

    // Input word.
    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] put_data;
        logic       rx_pending;
        logic [7:0] rx_data;
        logic       tx_ready;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic       op_ok;
        logic [7:0] get_data;
        logic       tx_write;
        logic [7:0] tx_data;
        logic       rx_dropped;
        logic       tx_irq_on;
        logic       tx_queue_empty;
    } t_out_word;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage
`default_nettype wire

### rtl/ubrf_ctrl.sv
// Controller state machine that sequences one word at a time through the datapath.
`default_nettype none
module ubrf_ctrl
    import ubrf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            ST_DONE: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // An execute step always follows directly on a load.
    a_exec_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> $past(o_cmd.load))
        else $error("execute step without a preceding load");

    // A result is shown only after an execute step, and stays until taken.
    a_out_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_cmd.exec))
        else $error("result shown without an execute step");

    // Only one word is ever in flight.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a result waits");
`endif

endmodule
`default_nettype wire

### rtl/ubrf_dp.sv
// Datapath: both ring memories, their pointers, the interrupt enables and the result register.
`default_nettype none
module ubrf_dp
    import ubrf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_wdata,
    input  wire t_cmd      i_cmd,
    input  wire t_in_word  i_in_word,
    output t_out_word      o_out_word
);

    logic [7:0]          r_rx_mem [RX_DEPTH];
    logic [7:0]          r_tx_mem [TX_DEPTH];
    logic [7:0]          r_rx_rd;
    logic [7:0]          r_tx_rd;
    logic [RX_PTR_W-1:0] r_rx_head, r_rx_tail, n_rx_head, n_rx_tail;
    logic [TX_PTR_W-1:0] r_tx_head, r_tx_tail, n_tx_head, n_tx_tail;
    logic [RX_PTR_W-1:0] rx_head_inc, rx_tail_inc;
    logic [TX_PTR_W-1:0] tx_head_inc, tx_tail_inc;
    logic                r_tx_irq_en, n_tx_irq_en;
    logic                r_rx_irq_en;
    t_in_word            r_in;
    t_out_word           r_out, n_out;
    logic                rx_we, tx_we, tx_pop;
    logic                rx_empty, rx_full, tx_empty, tx_full;

    // Pointer increments with wrap at the ring depth.
    assign rx_head_inc = (r_rx_head == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : r_rx_head + 1'b1;
    assign rx_tail_inc = (r_rx_tail == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : r_rx_tail + 1'b1;
    assign tx_head_inc = (r_tx_head == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : r_tx_head + 1'b1;
    assign tx_tail_inc = (r_tx_tail == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : r_tx_tail + 1'b1;

    assign rx_empty = (r_rx_head == r_rx_tail);
    assign rx_full  = (rx_head_inc == r_rx_tail);
    assign tx_empty = (r_tx_head == r_tx_tail);
    assign tx_full  = (tx_head_inc == r_tx_tail);

    // Operation decode for the captured word.
    always_comb begin
        n_rx_head   = r_rx_head;
        n_rx_tail   = r_rx_tail;
        n_tx_head   = r_tx_head;
        n_tx_tail   = r_tx_tail;
        n_tx_irq_en = r_tx_irq_en;
        rx_we       = 1'b0;
        tx_we       = 1'b0;
        tx_pop      = 1'b0;
        n_out       = '0;
        case (r_in.opcode)
            OP_PUT: begin
                if (!tx_full) begin
                    tx_we       = 1'b1;
                    n_tx_head   = tx_head_inc;
                    n_tx_irq_en = 1'b1;
                    n_out.op_ok = 1'b1;
                end
            end
            OP_GET: begin
                if (!rx_empty) begin
                    n_rx_tail      = rx_tail_inc;
                    n_out.op_ok    = 1'b1;
                    n_out.get_data = r_rx_rd;
                end
            end
            OP_IRQ: begin
                if (r_rx_irq_en && r_in.rx_pending) begin
                    if (rx_full) begin
                        n_out.rx_dropped = 1'b1;
                    end else begin
                        rx_we     = 1'b1;
                        n_rx_head = rx_head_inc;
                    end
                end
                if (r_tx_irq_en && r_in.tx_ready) begin
                    if (tx_empty) begin
                        n_tx_irq_en = 1'b0;
                    end else begin
                        tx_pop = 1'b1;
                    end
                end
            end
            OP_FLUSH: begin
                n_tx_irq_en = 1'b0;
                tx_pop      = r_in.tx_ready && !tx_empty;
            end
            default: begin
                n_tx_irq_en = r_tx_irq_en;
            end
        endcase
        // A popped transmit byte leaves the ring this step.
        if (tx_pop) begin
            n_tx_tail      = tx_tail_inc;
            n_out.tx_write = 1'b1;
            n_out.tx_data  = r_tx_rd;
        end
        n_out.tx_irq_on      = n_tx_irq_en;
        n_out.tx_queue_empty = (n_tx_head == n_tx_tail);
    end

    // Control registers: pointers and interrupt enables.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_tx_head   <= '0;
            r_tx_tail   <= '0;
            r_tx_irq_en <= 1'b0;
            r_rx_irq_en <= 1'b1;
        end else begin
            if (i_cmd.exec) begin
                r_rx_head   <= n_rx_head;
                r_rx_tail   <= n_rx_tail;
                r_tx_head   <= n_tx_head;
                r_tx_tail   <= n_tx_tail;
                r_tx_irq_en <= n_tx_irq_en;
            end
            if (i_cfg_we) begin
                r_rx_irq_en <= i_cfg_wdata;
            end
        end
    end

    // Input capture and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_word;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    // Receive ring memory; the read port follows the tail every cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && rx_we) begin
            r_rx_mem[r_rx_head] <= r_in.rx_data;
        end
        r_rx_rd <= r_rx_mem[r_rx_tail];
    end

    // Transmit ring memory; the read port follows the tail every cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && tx_we) begin
            r_tx_mem[r_tx_head] <= r_in.put_data;
        end
        r_tx_rd <= r_tx_mem[r_tx_tail];
    end

    assign o_out_word = r_out;

`ifndef SYNTHESIS
    // A successful put always leaves the transmit interrupt enabled.
    a_put_sets_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && tx_we) |=> r_tx_irq_en)
        else $error("put did not enable the transmit interrupt");

    // A stored received byte leaves the receive ring non-empty.
    a_rx_store_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && rx_we) |=> (r_rx_head != r_rx_tail))
        else $error("receive ring empty after a store");

    // Bytes are only sent to the line from a non-empty transmit ring.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && tx_pop) |-> (r_tx_head != r_tx_tail))
        else $error("transmit pop from an empty ring");
`endif

endmodule
`default_nettype wire

### rtl/uart_buffered_ring_fifos.sv
// Top level of the buffered UART ring FIFO block: controller plus datapath.
//
//   Channel   Direction  Handshake                 Word type
//   input     in         i_in_valid / o_in_ready   t_in_word
//   result    out        o_out_valid / i_out_ready t_out_word
//   config    in         i_cfg_we (no wait)        i_cfg_wdata, 1 bit
//
// A word is accepted and captured in the idle cycle; the next cycle executes it
// and loads the result register, which is shown from the cycle after that until
// it is taken. The next word is taken in the cycle after the result is taken, so
// the block takes no new word while one is in flight; the input capture register
// sets the execute cycle. Reset is synchronous and needs no clearing pass; a
// stalled result simply holds the block.
`default_nettype none
module uart_buffered_ring_fifos
    import ubrf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_wdata,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_word i_in_word,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_word     o_out_word
);

    t_cmd cmd;

    // Sequencing.
    ubrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Rings, pointers and result.
    ubrf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .i_in_word   (i_in_word),
        .o_out_word  (o_out_word)
    );

endmodule
`default_nettype wire
